FILE: rtl/core/whcp_pkg.sv
// Shared types, tags, status codes and helpers of the WAV header chunk parser.
`timescale 1ns / 1ps

package whcp_pkg;

   // Four-character tags as they appear in file order, first byte in the top bits.
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
   localparam logic [15:0] FORMAT_PCM     = 16'd1;
   localparam logic [15:0] MONO_CHANNELS  = 16'd1;
   localparam logic [15:0] PCM16_BITS     = 16'd16;

   localparam logic [31:0] RATE_44K1 = 32'd44100;
   localparam logic [31:0] RATE_22K05 = 32'd22050;
   localparam logic [31:0] RATE_48K  = 32'd48000;

   localparam int unsigned STATUS_W = 4;

   localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_RIFF    = 4'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_WAVE    = 4'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 4'd3;
   localparam logic [STATUS_W-1:0] ST_FMT_SMALL   = 4'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_PCM     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_NO_FMT      = 4'd6;
   localparam logic [STATUS_W-1:0] ST_NO_DATA     = 4'd7;
   localparam logic [STATUS_W-1:0] ST_NOT_MONO16  = 4'd8;

   typedef struct packed {
      logic [STATUS_W-1:0] parse_status;
      logic [31:0]         audio_offset;
      logic [31:0]         audio_length;
      logic [15:0]         channel_count;
      logic [31:0]         samples_per_second;
      logic [15:0]         sample_bits;
      logic                rate_unusual;
   } whcp_result_type;

   // True when the sample rate is none of the common ones.
   function automatic logic rate_is_unusual(input logic [31:0] rate);
      return (rate != RATE_44K1) && (rate != RATE_22K05) && (rate != RATE_48K);
   endfunction

endpackage

FILE: rtl/core/wav_header_chunk_parser.sv
// Top level of the WAV header chunk parser: byte input, one result per file.
`timescale 1ns / 1ps

// The req channel carries a WAV file one byte per beat, in file order, with
// req_end_of_file set on the final byte. The parser checks the RIFF and WAVE
// tags, walks the chunks, captures the fmt fields and the data chunk position,
// and sends exactly one beat on the rsp channel per file: when both fmt and
// data are known, at the first error, or at the end of the file.
// The parse state is updated in the cycle the byte is accepted, so a new
// byte can be accepted on every clock edge unless a result waits on a
// stalled receiver. The result appears on rsp in the cycle after the byte
// that completes it is accepted and is held in a single output register.
// Bytes after a result are dropped until the end-of-file byte, and the byte
// after that starts a new file.
// req_stall rises only while a result sits in the output register and the
// receiver stalls; the held result then stays unchanged on the rsp ports.
// Reset is synchronous and active high; it empties the output register and
// returns the parser to the start of a file.
module wav_header_chunk_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_parse_status,
   output logic [31:0] rsp_audio_offset,
   output logic [31:0] rsp_audio_length,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_samples_per_second,
   output logic [15:0] rsp_sample_bits,
   output logic        rsp_rate_unusual
);
   import whcp_pkg::*;

   logic            req_accept;
   logic            result_valid;
   whcp_result_type result;
   whcp_result_type rsp_data;
   logic            out_blocked;

   // A byte is taken unless a result is waiting on a stalled receiver.
   assign req_stall  = out_blocked;
   assign req_accept = req_valid & ~out_blocked;

   whcp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_accept),
      .stream_byte  (req_stream_byte),
      .end_of_file  (req_end_of_file),
      .result_valid (result_valid),
      .result       (result)
   );

   whcp_rsp_reg u_rsp_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (result_valid),
      .load_data    (result),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .full_blocked (out_blocked),
      .rsp_data     (rsp_data)
   );

   assign rsp_parse_status       = rsp_data.parse_status;
   assign rsp_audio_offset       = rsp_data.audio_offset;
   assign rsp_audio_length       = rsp_data.audio_length;
   assign rsp_channel_count      = rsp_data.channel_count;
   assign rsp_samples_per_second = rsp_data.samples_per_second;
   assign rsp_sample_bits        = rsp_data.sample_bits;
   assign rsp_rate_unusual       = rsp_data.rate_unusual;

   // The input is held back only while a result is waiting.
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall raised with no result waiting");

   // Status codes stay within the defined set.
   a_status_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_parse_status <= ST_NOT_MONO16))
      else $error("result status out of range");

   // The rate warning only accompanies a completed walk.
   a_unusual_only_complete : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rate_unusual) |->
         (rsp_parse_status == ST_OK || rsp_parse_status == ST_NOT_MONO16))
      else $error("rate warning on an error status");

   // An accepted status means mono 16-bit audio.
   a_ok_is_mono16 : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parse_status == ST_OK) |->
         (rsp_channel_count == MONO_CHANNELS && rsp_sample_bits == PCM16_BITS))
      else $error("ok status without mono 16-bit format");

endmodule

FILE: rtl/core/whcp_parser.sv
// Per-beat parse state and the next-state logic that walks the RIFF chunks.
`timescale 1ns / 1ps

module whcp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               stream_byte,
   input  logic                     end_of_file,
   output logic                     result_valid,
   output whcp_pkg::whcp_result_type result
);
   import whcp_pkg::*;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_CHUNK  = 3'd1;
   localparam logic [2:0] PH_FMT    = 3'd2;
   localparam logic [2:0] PH_SKIP   = 3'd3;
   localparam logic [2:0] PH_DRAIN  = 3'd4;

   localparam logic [4:0] RIFF_LAST_IDX  = 5'd3;
   localparam logic [4:0] HDR_LAST_IDX   = 5'd11;
   localparam logic [4:0] TAG_LAST_IDX   = 5'd3;
   localparam logic [4:0] CHUNK_LAST_IDX = 5'd7;
   localparam logic [4:0] FMT_LAST_IDX   = 5'd15;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [4:0]  idx_ff, idx_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [32:0] skip_ff, skip_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic        data_seen_ff, data_seen_in;
   logic [15:0] fmt_tag_ff, fmt_tag_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] length_ff, length_in;

   logic                emit;
   logic [STATUS_W-1:0] status;
   logic [32:0]         chunk_total;
   logic [STATUS_W-1:0] final_status;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff + 32'd1;
      idx_in       = idx_ff;
      tag_in       = tag_ff;
      size_in      = size_ff;
      skip_in      = skip_ff;
      fmt_seen_in  = fmt_seen_ff;
      data_seen_in = data_seen_ff;
      fmt_tag_in   = fmt_tag_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      bits_in      = bits_ff;
      offset_in    = offset_ff;
      length_in    = length_ff;
      emit         = 1'b0;
      status       = ST_OK;
      chunk_total  = '0;
      final_status = ST_OK;
      result       = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            tag_in = {tag_ff[23:0], stream_byte};
            if (idx_ff == RIFF_LAST_IDX && tag_in != TAG_RIFF) begin
               emit   = 1'b1;
               status = ST_NOT_RIFF;
            end else if (idx_ff >= HDR_LAST_IDX) begin
               if (tag_in != TAG_WAVE) begin
                  emit   = 1'b1;
                  status = ST_NOT_WAVE;
               end else begin
                  skip_in  = '0;
                  phase_in = PH_CHUNK;
                  idx_in   = '0;
                  tag_in   = '0;
                  size_in  = '0;
               end
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         PH_CHUNK: begin
            if (idx_ff <= TAG_LAST_IDX) begin
               tag_in = {tag_ff[23:0], stream_byte};
            end else if (idx_ff <= CHUNK_LAST_IDX) begin
               case (idx_ff[1:0])
                  2'd0:    size_in[7:0]   = size_ff[7:0]   | stream_byte;
                  2'd1:    size_in[15:8]  = size_ff[15:8]  | stream_byte;
                  2'd2:    size_in[23:16] = size_ff[23:16] | stream_byte;
                  default: size_in[31:24] = size_ff[31:24] | stream_byte;
               endcase
            end
            if (idx_ff >= CHUNK_LAST_IDX) begin
               // Odd-sized chunks carry one pad byte.
               chunk_total = {1'b0, size_in} + {32'd0, size_in[0]};
               if (tag_in == TAG_FMT) begin
                  if (size_in < FMT_MIN_SIZE) begin
                     emit   = 1'b1;
                     status = ST_FMT_SMALL;
                  end else begin
                     phase_in   = PH_FMT;
                     idx_in     = '0;
                     skip_in    = chunk_total - {1'b0, FMT_MIN_SIZE};
                     fmt_tag_in = '0;
                     chan_in    = '0;
                     rate_in    = '0;
                     bits_in    = '0;
                  end
               end else begin
                  if (tag_in == TAG_DATA) begin
                     offset_in    = pos_ff + 32'd1;
                     length_in    = size_in;
                     data_seen_in = 1'b1;
                  end
                  if (tag_in == TAG_DATA && fmt_seen_ff) begin
                     emit   = 1'b1;
                     status = ST_OK;
                  end else begin
                     skip_in  = chunk_total;
                     phase_in = (chunk_total != '0) ? PH_SKIP : PH_CHUNK;
                     idx_in   = '0;
                     tag_in   = '0;
                     size_in  = '0;
                  end
               end
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         PH_FMT: begin
            case (idx_ff)
               5'd0:    fmt_tag_in[7:0]  = fmt_tag_ff[7:0]  | stream_byte;
               5'd1:    fmt_tag_in[15:8] = fmt_tag_ff[15:8] | stream_byte;
               5'd2:    chan_in[7:0]     = chan_ff[7:0]     | stream_byte;
               5'd3:    chan_in[15:8]    = chan_ff[15:8]    | stream_byte;
               5'd4:    rate_in[7:0]     = rate_ff[7:0]     | stream_byte;
               5'd5:    rate_in[15:8]    = rate_ff[15:8]    | stream_byte;
               5'd6:    rate_in[23:16]   = rate_ff[23:16]   | stream_byte;
               5'd7:    rate_in[31:24]   = rate_ff[31:24]   | stream_byte;
               5'd14:   bits_in[7:0]     = bits_ff[7:0]     | stream_byte;
               5'd15:   bits_in[15:8]    = bits_ff[15:8]    | stream_byte;
               default: ;
            endcase
            if (idx_ff >= FMT_LAST_IDX) begin
               if (fmt_tag_in != FORMAT_PCM) begin
                  emit   = 1'b1;
                  status = ST_NOT_PCM;
               end else begin
                  fmt_seen_in = 1'b1;
                  if (data_seen_ff) begin
                     emit   = 1'b1;
                     status = ST_OK;
                  end else begin
                     phase_in = (skip_ff != '0) ? PH_SKIP : PH_CHUNK;
                     idx_in   = '0;
                     tag_in   = '0;
                     size_in  = '0;
                  end
               end
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         PH_SKIP: begin
            if (skip_ff != '0) begin
               skip_in = skip_ff - 33'd1;
            end
            if (skip_in == '0) begin
               phase_in = PH_CHUNK;
               idx_in   = '0;
               tag_in   = '0;
               size_in  = '0;
            end
         end
         default: ;
      endcase

      // A finished walk reports non-mono or non-16-bit audio as a rejection.
      final_status = (chan_in != MONO_CHANNELS || bits_in != PCM16_BITS) ? ST_NOT_MONO16
                                                                         : ST_OK;
      if (emit && status == ST_OK) begin
         status = final_status;
      end
      if (emit) begin
         phase_in = PH_DRAIN;
      end

      if (end_of_file && !emit && phase_in != PH_DRAIN) begin
         emit = 1'b1;
         if ((phase_in == PH_CHUNK && idx_in == '0) || phase_in == PH_SKIP) begin
            status = fmt_seen_in ? ST_NO_DATA : ST_NO_FMT;
         end else begin
            status = ST_TRUNCATED;
         end
      end

      result.parse_status       = status;
      result.audio_offset       = offset_in;
      result.audio_length       = length_in;
      result.channel_count      = chan_in;
      result.samples_per_second = rate_in;
      result.sample_bits        = bits_in;
      result.rate_unusual       = (status == ST_OK || status == ST_NOT_MONO16) ?
                                  rate_is_unusual(rate_in) : 1'b0;

      // The beat after the last one of a file starts a fresh parse.
      if (end_of_file) begin
         phase_in     = PH_HEADER;
         pos_in       = '0;
         idx_in       = '0;
         tag_in       = '0;
         size_in      = '0;
         skip_in      = '0;
         fmt_seen_in  = 1'b0;
         data_seen_in = 1'b0;
         fmt_tag_in   = '0;
         chan_in      = '0;
         rate_in      = '0;
         bits_in      = '0;
         offset_in    = '0;
         length_in    = '0;
      end
   end

   assign result_valid = step_en & emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         idx_ff       <= '0;
         tag_ff       <= '0;
         size_ff      <= '0;
         skip_ff      <= '0;
         fmt_seen_ff  <= 1'b0;
         data_seen_ff <= 1'b0;
         fmt_tag_ff   <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         offset_ff    <= '0;
         length_ff    <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         tag_ff       <= tag_in;
         size_ff      <= size_in;
         skip_ff      <= skip_in;
         fmt_seen_ff  <= fmt_seen_in;
         data_seen_ff <= data_seen_in;
         fmt_tag_ff   <= fmt_tag_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         offset_ff    <= offset_in;
         length_ff    <= length_in;
      end
   end

endmodule

FILE: rtl/core/whcp_rsp_reg.sv
// Result register that holds one parse result until the receiver takes it.
`timescale 1ns / 1ps

module whcp_rsp_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  whcp_pkg::whcp_result_type load_data,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic                     full_blocked,
   output whcp_pkg::whcp_result_type rsp_data
);
   import whcp_pkg::*;

   logic            valid_ff, valid_in;
   whcp_result_type data_ff, data_in;

   // Blocked only while a held result waits on a stalled receiver.
   assign full_blocked = valid_ff & rsp_stall;

   always_comb begin
      valid_in = valid_ff & rsp_stall;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the WAV header chunk parser, with its own byte-level predictor.
`timescale 1ns / 1ps

// The stimulus is a stream of WAV files that go in one byte per beat, with the
// end-of-file flag on the final byte of each file. First comes a short
// directed set of files: the plain case, every error status, the early RIFF
// check, ends at every point of the walk, repeated fmt chunks, odd and huge
// chunk sizes and extreme field values. Then come random files. Most of them
// are well formed with random content, and the rest are noise, files with one
// corrupted byte, or files cut short.
//
// The predictor follows the parser byte by byte as each beat is accepted and
// queues the report that the file will produce. The monitor compares every
// report that leaves the block against the oldest queued one, field by field.
module tb_top;
   import whcp_pkg::*;

   localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
   localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
   localparam logic [31:0] TAG_WAVF = 32'h5741_5646;
   localparam logic [7:0]  CHAR_R   = 8'h52;
   localparam logic [7:0]  CHAR_I   = 8'h49;

   // Random bytes wanted after the directed files, and the least number of
   // random files (one report each).
   localparam int unsigned RANDOM_BYTES      = 900;
   localparam int unsigned RANDOM_FILES_MIN  = 8;
   // Once this few bytes are left to send, neither side idles any more.
   localparam int unsigned QUIET_TAIL        = 150;
   // The receiver holds off once for this long, after this many beats.
   localparam int unsigned LONG_HOLD_AFTER   = 700;
   localparam int unsigned LONG_HOLD_CYCLES  = 400;
   localparam int unsigned SETTLE_CYCLES     = 20;

   // Where the predictor stands inside the current file.
   typedef enum logic [2:0] {
      WALK_HEADER,
      WALK_CHUNK,
      WALK_FMT,
      WALK_SKIP,
      WALK_DRAIN
   } walk_phase_type;

   // One input beat. A beat marked drain_first is held back until every
   // report of the earlier files has come out.
   typedef struct {
      logic [7:0] value;
      logic       last;
      logic       drain_first;
   } wav_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_parse_status;
   logic [31:0] rsp_audio_offset;
   logic [31:0] rsp_audio_length;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_samples_per_second;
   logic [15:0] rsp_sample_bits;
   logic        rsp_rate_unusual;

   wav_byte_type    byte_stream[$];
   logic [7:0]      file_buf[$];
   whcp_result_type header_reports[$];

   int unsigned error_count = 0;
   int unsigned accepted_count = 0;
   logic        byte_taken = 1'b0;

   // Predictor state for the file in progress.
   walk_phase_type walk_phase;
   logic [31:0] pos_count;
   logic [4:0]  field_idx;
   logic [31:0] tag_acc;
   logic [31:0] size_acc;
   logic [32:0] skip_left;
   logic        fmt_found;
   logic        data_found;
   logic [15:0] fmt_code;
   logic [15:0] chan_val;
   logic [31:0] rate_val;
   logic [15:0] bits_val;
   logic [31:0] offs_val;
   logic [31:0] len_val;

   // Sender and receiver pacing.
   wav_byte_type head_item;
   int unsigned tx_gap = 0;
   int unsigned tx_idle_pct = 0;
   int unsigned sent_count = 0;
   int unsigned rx_gap = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned rx_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   whcp_result_type want;

   wav_header_chunk_parser u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_stream_byte        (req_stream_byte),
      .req_end_of_file        (req_end_of_file),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_parse_status       (rsp_parse_status),
      .rsp_audio_offset       (rsp_audio_offset),
      .rsp_audio_length       (rsp_audio_length),
      .rsp_channel_count      (rsp_channel_count),
      .rsp_samples_per_second (rsp_samples_per_second),
      .rsp_sample_bits        (rsp_sample_bits),
      .rsp_rate_unusual       (rsp_rate_unusual)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Everything goes back to the start of a file, as after reset.
   function automatic void clear_file();
      walk_phase = WALK_HEADER;
      pos_count  = 32'd0;
      field_idx  = 5'd0;
      tag_acc    = 32'd0;
      size_acc   = 32'd0;
      skip_left  = 33'd0;
      fmt_found  = 1'b0;
      data_found = 1'b0;
      fmt_code   = 16'd0;
      chan_val   = 16'd0;
      rate_val   = 32'd0;
      bits_val   = 16'd0;
      offs_val   = 32'd0;
      len_val    = 32'd0;
   endfunction

   // Queues the one report of this file; the rest of the file is dropped.
   // The rate flag only means something when the fmt fields were accepted.
   function automatic void report_file(logic [3:0] code);
      whcp_result_type r;
      r.parse_status       = code;
      r.audio_offset       = offs_val;
      r.audio_length       = len_val;
      r.channel_count      = chan_val;
      r.samples_per_second = rate_val;
      r.sample_bits        = bits_val;
      r.rate_unusual       = (code == ST_OK || code == ST_NOT_MONO16) &&
                             rate_val != RATE_44K1 && rate_val != RATE_22K05 &&
                             rate_val != RATE_48K;
      header_reports.push_back(r);
      walk_phase = WALK_DRAIN;
   endfunction

   // Both chunks are known: only mono 16-bit audio is acceptable.
   function automatic void report_format();
      report_file((chan_val != MONO_CHANNELS || bits_val != PCM16_BITS) ?
                  ST_NOT_MONO16 : ST_OK);
   endfunction

   // Moves on to the next chunk header, after skipping the given byte count.
   function automatic void open_chunk(logic [32:0] skip);
      skip_left  = skip;
      walk_phase = (skip != 33'd0) ? WALK_SKIP : WALK_CHUNK;
      field_idx  = 5'd0;
      tag_acc    = 32'd0;
      size_acc   = 32'd0;
   endfunction

   // Advances the predicted parse by one accepted byte.
   function automatic void walk_wav_byte(logic [7:0] b, logic last);
      logic [32:0] padded;
      case (walk_phase)
         WALK_HEADER: begin
            tag_acc = {tag_acc[23:0], b};
            // The RIFF tag is judged as soon as its fourth byte is in.
            if (field_idx == 5'd3 && tag_acc != TAG_RIFF) begin
               report_file(ST_NOT_RIFF);
            end else if (field_idx >= 5'd11) begin
               if (tag_acc != TAG_WAVE) begin
                  report_file(ST_NOT_WAVE);
               end else begin
                  open_chunk(33'd0);
               end
            end else begin
               field_idx = field_idx + 5'd1;
            end
         end
         WALK_CHUNK: begin
            if (field_idx < 5'd4) begin
               tag_acc = {tag_acc[23:0], b};
            end else if (field_idx < 5'd8) begin
               size_acc = size_acc | ({24'd0, b} << (8 * (field_idx - 5'd4)));
            end
            if (field_idx >= 5'd7) begin
               // Odd sizes carry one pad byte; 33 bits keep 0xFFFFFFFF + 1 exact.
               padded = {1'b0, size_acc} + {32'd0, size_acc[0]};
               if (tag_acc == TAG_FMT) begin
                  if (size_acc < FMT_MIN_SIZE) begin
                     report_file(ST_FMT_SMALL);
                  end else begin
                     // A repeated fmt chunk starts its fields over.
                     walk_phase = WALK_FMT;
                     field_idx  = 5'd0;
                     skip_left  = padded - 33'd16;
                     fmt_code   = 16'd0;
                     chan_val   = 16'd0;
                     rate_val   = 32'd0;
                     bits_val   = 16'd0;
                  end
               end else if (tag_acc == TAG_DATA) begin
                  offs_val   = pos_count + 32'd1;
                  len_val    = size_acc;
                  data_found = 1'b1;
                  if (fmt_found) begin
                     report_format();
                  end else begin
                     open_chunk(padded);
                  end
               end else begin
                  open_chunk(padded);
               end
            end else begin
               field_idx = field_idx + 5'd1;
            end
         end
         WALK_FMT: begin
            if (field_idx < 5'd2) begin
               fmt_code = fmt_code | ({8'd0, b} << (8 * field_idx));
            end else if (field_idx < 5'd4) begin
               chan_val = chan_val | ({8'd0, b} << (8 * (field_idx - 5'd2)));
            end else if (field_idx < 5'd8) begin
               rate_val = rate_val | ({24'd0, b} << (8 * (field_idx - 5'd4)));
            end else if (field_idx >= 5'd14 && field_idx < 5'd16) begin
               bits_val = bits_val | ({8'd0, b} << (8 * (field_idx - 5'd14)));
            end
            if (field_idx >= 5'd15) begin
               if (fmt_code != FORMAT_PCM) begin
                  report_file(ST_NOT_PCM);
               end else begin
                  fmt_found = 1'b1;
                  if (data_found) begin
                     report_format();
                  end else begin
                     open_chunk(skip_left);
                  end
               end
            end else begin
               field_idx = field_idx + 5'd1;
            end
         end
         WALK_SKIP: begin
            if (skip_left != 33'd0) begin
               skip_left = skip_left - 33'd1;
            end
            if (skip_left == 33'd0) begin
               open_chunk(33'd0);
            end
         end
         default: begin
         end
      endcase
      pos_count = pos_count + 32'd1;

      // The end of the file settles a walk that is still open: at a chunk
      // boundary or inside a skipped chunk the missing chunk is named, and
      // anywhere else the file counts as truncated.
      if (last) begin
         if (walk_phase != WALK_DRAIN) begin
            if ((walk_phase == WALK_CHUNK && field_idx == 5'd0) ||
                walk_phase == WALK_SKIP) begin
               report_file(fmt_found ? ST_NO_DATA : ST_NO_FMT);
            end else begin
               report_file(ST_TRUNCATED);
            end
         end
         clear_file();
      end
   endfunction

   // ------------------------------------------------------------------
   // File builders
   // ------------------------------------------------------------------

   function automatic void put_u16(logic [15:0] v);
      file_buf.push_back(v[7:0]);
      file_buf.push_back(v[15:8]);
   endfunction

   function automatic void put_u32(logic [31:0] v);
      put_u16(v[15:0]);
      put_u16(v[31:16]);
   endfunction

   // Tags go out in reading order, so the top byte first.
   function automatic void put_tag(logic [31:0] t);
      file_buf.push_back(t[31:24]);
      file_buf.push_back(t[23:16]);
      file_buf.push_back(t[15:8]);
      file_buf.push_back(t[7:0]);
   endfunction

   function automatic void put_noise(int unsigned count);
      repeat (count) file_buf.push_back(8'($urandom));
   endfunction

   function automatic void put_riff_header();
      put_tag(TAG_RIFF);
      put_u32($urandom);
      put_tag(TAG_WAVE);
   endfunction

   // A chunk with a body is only written out when it is short; a huge size
   // leaves the rest of the file inside the skip.
   function automatic void put_chunk(logic [31:0] tag, logic [31:0] chunk_len);
      put_tag(tag);
      put_u32(chunk_len);
      if (chunk_len < 32'd64) put_noise(chunk_len + chunk_len[0]);
   endfunction

   function automatic void put_fmt(logic [31:0] chunk_len, logic [15:0] code,
                                   logic [15:0] chans, logic [31:0] rate,
                                   logic [15:0] bits);
      put_tag(TAG_FMT);
      put_u32(chunk_len);
      put_u16(code);
      put_u16(chans);
      put_u32(rate);
      put_u32($urandom);          // byte rate, not looked at
      put_u16(16'($urandom));     // block align, not looked at
      put_u16(bits);
      if (chunk_len > 32'd16 && chunk_len < 32'd64) begin
         put_noise(chunk_len - 32'd16 + chunk_len[0]);
      end
   endfunction

   // Moves the file under construction onto the beat queue.
   function automatic void commit_file(bit drain_first);
      wav_byte_type item;
      if (file_buf.size() == 0) file_buf.push_back(8'($urandom));
      foreach (file_buf[i]) begin
         item.value       = file_buf[i];
         item.last        = (i == file_buf.size() - 1);
         item.drain_first = drain_first && (i == 0);
         byte_stream.push_back(item);
      end
      file_buf.delete();
   endfunction

   function automatic logic [31:0] pick_chunk_len();
      case ($urandom_range(0, 39))
         0:       return 32'hFFFF_FFFF;
         1:       return $urandom;
         default: return $urandom_range(0, 24);
      endcase
   endfunction

   function automatic logic [15:0] pick_channels();
      case ($urandom_range(0, 3))
         0, 1:    return MONO_CHANNELS;
         2:       return 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(0, 5))
         0:       return RATE_44K1;
         1:       return RATE_22K05;
         2:       return RATE_48K;
         3:       return 32'd11025;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_bits();
      case ($urandom_range(0, 3))
         0, 1:    return PCM16_BITS;
         2:       return 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void put_random_fmt();
      logic [31:0] chunk_len;
      logic [15:0] code;
      case ($urandom_range(0, 19))
         0:       chunk_len = $urandom_range(0, 15);
         1:       chunk_len = 32'hFFFF_FFFF;
         default: chunk_len = $urandom_range(16, 24);
      endcase
      code = ($urandom_range(0, 7) == 0) ? 16'($urandom) : FORMAT_PCM;
      put_fmt(chunk_len, code, pick_channels(), pick_rate(), pick_bits());
   endfunction

   function automatic void put_side_chunks();
      repeat ($urandom_range(0, 2)) begin
         put_chunk(($urandom_range(0, 1) != 0) ? TAG_LIST : 32'($urandom), pick_chunk_len());
      end
   endfunction

   // Most files are well formed with random content and chunk order; the
   // others are noise, carry one corrupted byte, or are cut short.
   function automatic void build_random_file();
      int unsigned kind;
      int unsigned keep;
      bit          fmt_first;
      bit          want_fmt;
      bit          want_data;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         if (kind < 6) put_tag(TAG_RIFF);
         put_noise($urandom_range(1, 16));
         return;
      end
      fmt_first = 1'($urandom_range(0, 1));
      want_fmt  = ($urandom_range(0, 11) != 0);
      want_data = ($urandom_range(0, 11) != 0);
      put_riff_header();
      put_side_chunks();
      if (want_fmt && fmt_first) put_random_fmt();
      put_side_chunks();
      if (want_data) put_chunk(TAG_DATA, pick_chunk_len());
      if (want_fmt && !fmt_first) put_random_fmt();
      put_noise($urandom_range(0, 6));
      if (kind < 27) begin
         file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, file_buf.size());
         while (file_buf.size() > keep) void'(file_buf.pop_back());
      end
   endfunction

   function automatic int unsigned pick_idle_pct();
      case ($urandom_range(0, 3))
         0, 1:    return 0;
         2:       return 10;
         default: return 40;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------

   initial begin
      int unsigned directed_len;
      int unsigned random_files;

      clear_file();

      // Plain mono 16-bit file at 44.1 kHz.
      put_riff_header();
      put_fmt(32'd16, FORMAT_PCM, MONO_CHANNELS, RATE_44K1, PCM16_BITS);
      put_chunk(TAG_DATA, 32'd4);
      commit_file(1'b0);
      // Data ahead of fmt behind an odd-sized chunk; stereo at 48 kHz.
      put_riff_header();
      put_chunk(TAG_LIST, 32'd3);
      put_chunk(TAG_DATA, 32'd6);
      put_fmt(32'd16, FORMAT_PCM, 16'd2, RATE_48K, PCM16_BITS);
      commit_file(1'b0);
      // Two fmt chunks, the second one wins; trailing bytes are dropped.
      put_riff_header();
      put_fmt(32'd18, FORMAT_PCM, 16'd2, 32'd8000, 16'd8);
      put_fmt(32'd17, FORMAT_PCM, MONO_CHANNELS, RATE_22K05, PCM16_BITS);
      put_chunk(TAG_DATA, 32'd0);
      put_noise(5);
      commit_file(1'b0);
      // All-ones channel, rate and bits fields and a data chunk of the largest size.
      put_riff_header();
      put_fmt(32'd16, FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      put_chunk(TAG_DATA, 32'hFFFF_FFFF);
      commit_file(1'b0);
      // Mono 16-bit at an unusual rate.
      put_riff_header();
      put_fmt(32'd16, FORMAT_PCM, MONO_CHANNELS, 32'd11025, PCM16_BITS);
      put_chunk(TAG_DATA, 32'd2);
      commit_file(1'b0);
      // A four-byte file with the wrong tag is rejected as not RIFF.
      put_tag(TAG_RIFX);
      commit_file(1'b0);
      // Files of all-zero and all-ones bytes.
      repeat (6) file_buf.push_back(8'h00);
      commit_file(1'b0);
      repeat (6) file_buf.push_back(8'hFF);
      commit_file(1'b0);
      // Files of one and two bytes end inside the header.
      file_buf.push_back(CHAR_R);
      commit_file(1'b0);
      file_buf.push_back(CHAR_R);
      file_buf.push_back(CHAR_I);
      commit_file(1'b0);
      // Wrong WAVE tag.
      put_tag(TAG_RIFF);
      put_u32(32'd0);
      put_tag(TAG_WAVF);
      commit_file(1'b0);
      // Ends right after the header, at a chunk boundary.
      put_riff_header();
      commit_file(1'b0);
      // Ends inside a chunk header.
      put_riff_header();
      put_tag(TAG_FMT);
      put_u16(16'd16);
      commit_file(1'b0);
      // Ends inside the fmt body.
      put_riff_header();
      put_tag(TAG_FMT);
      put_u32(32'd16);
      put_u16(FORMAT_PCM);
      put_u16(MONO_CHANNELS);
      commit_file(1'b0);
      // fmt chunks too small to hold the fields.
      put_riff_header();
      put_fmt(32'd15, FORMAT_PCM, MONO_CHANNELS, RATE_44K1, PCM16_BITS);
      commit_file(1'b0);
      put_riff_header();
      put_fmt(32'd0, FORMAT_PCM, MONO_CHANNELS, RATE_44K1, PCM16_BITS);
      commit_file(1'b0);
      // Not PCM.
      put_riff_header();
      put_fmt(32'd16, 16'd3, MONO_CHANNELS, RATE_44K1, PCM16_BITS);
      put_chunk(TAG_DATA, 32'd2);
      commit_file(1'b0);
      // Data only, ending just after its padded body: no fmt.
      put_riff_header();
      put_chunk(TAG_DATA, 32'd5);
      commit_file(1'b0);
      // fmt, then the file ends inside a huge chunk: no data.
      put_riff_header();
      put_fmt(32'd16, FORMAT_PCM, MONO_CHANNELS, RATE_44K1, PCM16_BITS);
      put_chunk(TAG_LIST, 32'hFFFF_FFFF);
      put_noise(3);
      commit_file(1'b0);
      // Huge odd fmt size: its padded size needs the 33rd bit.
      put_riff_header();
      put_fmt(32'hFFFF_FFFF, FORMAT_PCM, MONO_CHANNELS, RATE_48K, PCM16_BITS);
      put_noise(4);
      commit_file(1'b0);
      // An empty chunk falls straight through to the next header.
      put_riff_header();
      put_chunk(TAG_LIST, 32'd0);
      put_fmt(32'd16, FORMAT_PCM, MONO_CHANNELS, RATE_48K, PCM16_BITS);
      put_chunk(TAG_DATA, 32'd1);
      commit_file(1'b0);

      // Random files. The first one waits until the directed reports are
      // all out, and a few more pause the same way.
      directed_len = byte_stream.size();
      random_files = 0;
      while (byte_stream.size() < directed_len + RANDOM_BYTES ||
             random_files < RANDOM_FILES_MIN) begin
         build_random_file();
         commit_file(random_files == 0 || $urandom_range(0, 11) == 0);
         random_files++;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every beat accepted, every report back, then a few quiet cycles to
      // catch anything extra.
      while (byte_stream.size() != 0 || req_valid) @(posedge clock);
      while (header_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && header_reports.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sender: one beat in flight, changed only after it was taken
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (tx_gap != 0) begin
            tx_gap = tx_gap - 1;
            req_valid <= 1'b0;
         end else if (byte_stream.size() == 0 ||
                      (byte_stream[0].drain_first && header_reports.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (byte_stream.size() >= QUIET_TAIL &&
                      $urandom_range(0, 99) < tx_idle_pct) begin
            // An idle burst begins with this cycle; tx_gap counts the rest of it.
            tx_gap = $urandom_range(0, 16);
            req_valid <= 1'b0;
         end else begin
            head_item = byte_stream.pop_front();
            req_valid       <= 1'b1;
            req_stream_byte <= head_item.value;
            req_end_of_file <= head_item.last;
            sent_count++;
            if (sent_count % 64 == 0) tx_idle_pct = pick_idle_pct();
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts and one long hold-off
   // ------------------------------------------------------------------

   // The long hold-off keeps a report parked in the output register while the
   // sender keeps offering bytes, so the block has to stall its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles % 128 == 0) rx_stall_pct = pick_idle_pct();
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && accepted_count >= LONG_HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (rx_gap != 0) begin
            rx_gap = rx_gap - 1;
            rsp_stall <= 1'b1;
         end else if (byte_stream.size() >= QUIET_TAIL &&
                      $urandom_range(0, 99) < rx_stall_pct) begin
            rx_gap = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Input side: each accepted beat advances the predictor
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         byte_taken <= 1'b0;
      end else begin
         byte_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            accepted_count++;
            walk_wav_byte(req_stream_byte, req_end_of_file);
         end
      end
   end

   // ------------------------------------------------------------------
   // Output side: compare each report with the oldest prediction
   // ------------------------------------------------------------------

   function automatic void check_field(string name, logic [31:0] exp_val,
                                       logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (header_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual status %0d",
                     $time, rsp_parse_status);
            error_count++;
         end else begin
            want = header_reports.pop_front();
            check_field("parse_status", want.parse_status, rsp_parse_status);
            check_field("audio_offset", want.audio_offset, rsp_audio_offset);
            check_field("audio_length", want.audio_length, rsp_audio_length);
            check_field("channel_count", want.channel_count, rsp_channel_count);
            check_field("samples_per_second", want.samples_per_second,
                        rsp_samples_per_second);
            check_field("sample_bits", want.sample_bits, rsp_sample_bits);
            check_field("rate_unusual", want.rate_unusual, rsp_rate_unusual);
         end
      end
   end

endmodule
